@@ rtl/core/dflru_pkg.sv @@
// Shared types and constants for the dirty-first LRU replacer.
// No dependencies; imported by every module of the block.
`default_nettype none
package dflru_pkg;

	// Fixed field and stamp widths
	localparam int ACTION_W     = 2;
	localparam int SET_IDX_W    = 6;
	localparam int WAY_IDX_W    = 3;
	localparam int STAMP_W      = 32;
	localparam int KEY_W        = STAMP_W + 1;
	localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

	// Default geometry
	localparam int DEF_NUM_SETS = 64;
	localparam int DEF_NUM_WAYS = 8;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INVAL  = 2'd0,
		ACT_TOUCH  = 2'd1,
		ACT_FILL   = 2'd2,
		ACT_VICTIM = 2'd3
	} action_t;

	typedef struct packed {
		action_t                action;
		logic [SET_IDX_W-1:0]   set_index;
		logic [WAY_IDX_W-1:0]   way;
		logic                   is_write;
	} req_t;

	typedef struct packed {
		logic [WAY_IDX_W-1:0]   victim_way;
		logic                   victim_dirty;
	} rsp_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Row memory port controls
	typedef struct packed {
		logic rd;
		logic wr;
	} mem_cmd_t;

	// Victim scan status
	typedef struct packed {
		logic busy;
		logic done;
		rsp_t res;
	} scan_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/dirty_first_lru_replacer.sv @@
// Dirty-first LRU replacer top level: sequencer, access clock, update path.
// Uses dflru_pkg, dflru_row_mem and dflru_victim_scan.
//
//  channel | valid     | stall     | payload       | beat
//  --------+-----------+-----------+---------------+------------------------------
//  request | req_valid | req_stall | req  (req_t)  | one access or victim query
//  result  | rsp_valid | rsp_stall | rsp  (rsp_t)  | one victim per query only
//
// Invalidate, touch and fill are a row read, then a modified write-back.
// A query is the row read, NUM_WAYS compares, the scan done flag, the result load
// and then idle; on a set out of range it skips the compares and returns zero.
// Reset clears the control state and the per-set valid flops; no clearing pass.
// A finished result waits in the output register while the next beat is taken;
// a query that finds that register still full holds until it drains.
`default_nettype none
module dirty_first_lru_replacer #(
	parameter int NUM_SETS = dflru_pkg::DEF_NUM_SETS,
	parameter int NUM_WAYS = dflru_pkg::DEF_NUM_WAYS
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire dflru_pkg::req_t req,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output dflru_pkg::rsp_t      rsp
);
	import dflru_pkg::*;

	localparam int AW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WW    = $clog2(NUM_WAYS);
	localparam int ROW_W = NUM_WAYS * (STAMP_W + 1);
	localparam int SW    = NUM_WAYS * STAMP_W;

	state_t          state_q, state_nxt;
	req_t            req_s1;
	logic            set_ok_s1;
	logic            way_ok_s1;
	logic [STAMP_W-1:0] clock_q;
	logic [STAMP_W-1:0] stamp_nxt;
	rsp_t            rsp_q;
	logic            rsp_valid_q;

	logic            accept;
	logic            rsp_free;
	logic            is_query;
	logic            do_update;
	logic            scan_start;
	logic            rsp_load;
	mem_cmd_t        mem_cmd;
	logic [ROW_W-1:0] rd_row;
	logic [ROW_W-1:0] wr_row;
	logic [NUM_WAYS-1:0][STAMP_W-1:0] rd_stamps;
	logic [NUM_WAYS-1:0]              rd_dirty;
	logic [NUM_WAYS-1:0][STAMP_W-1:0] wr_stamps;
	logic [NUM_WAYS-1:0]              wr_dirty;
	scan_sts_t       scan_sts;

	assign accept   = req_valid && !req_stall;
	assign rsp_free = !rsp_valid_q || !rsp_stall;
	assign is_query = (req_s1.action == ACT_VICTIM);

	// Capture the accepted beat and its range checks
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1    <= req;
			set_ok_s1 <= (32'(req.set_index) < NUM_SETS);
			way_ok_s1 <= (32'(req.way) < NUM_WAYS);
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = ST_RD;
				end
			end
			ST_RD: begin
				if (!is_query) begin
					state_nxt = ST_IDLE;
				end else if (set_ok_s1) begin
					state_nxt = ST_SCAN;
				end else begin
					state_nxt = ST_DONE;
				end
			end
			ST_SCAN: begin
				if (scan_sts.done) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (rsp_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		req_stall  = 1'b1;
		mem_cmd    = '0;
		do_update  = 1'b0;
		scan_start = 1'b0;
		rsp_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_stall  = 1'b0;
				mem_cmd.rd = req_valid;
			end
			ST_RD: begin
				do_update  = !is_query && set_ok_s1 && way_ok_s1;
				mem_cmd.wr = do_update;
				scan_start = is_query && set_ok_s1;
			end
			ST_SCAN: begin
			end
			ST_DONE: begin
				rsp_load = rsp_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Advance the access clock, saturating at its maximum
	assign stamp_nxt = (clock_q == STAMP_MAX) ? clock_q : clock_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= '0;
		end else if (do_update && (req_s1.action != ACT_INVAL)) begin
			clock_q <= stamp_nxt;
		end
	end

	// Modify the addressed way of the row read back
	assign rd_stamps = rd_row[SW-1:0];
	assign rd_dirty  = rd_row[ROW_W-1 -: NUM_WAYS];

	always_comb begin
		wr_stamps = rd_stamps;
		wr_dirty  = rd_dirty;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (int'(req_s1.way) == w) begin
				case (req_s1.action)
					ACT_INVAL: begin
						wr_stamps[w] = '0;
						wr_dirty[w]  = 1'b0;
					end
					ACT_TOUCH: begin
						wr_stamps[w] = stamp_nxt;
						wr_dirty[w]  = rd_dirty[w] | req_s1.is_write;
					end
					ACT_FILL: begin
						wr_stamps[w] = stamp_nxt;
						wr_dirty[w]  = req_s1.is_write;
					end
					default: begin
					end
				endcase
			end
		end
		wr_row = {wr_dirty, wr_stamps};
	end

	dflru_row_mem #(
		.NUM_SETS (NUM_SETS),
		.ROW_W    (ROW_W),
		.AW       (AW)
	) u_row_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (mem_cmd),
		.rd_addr (AW'(req.set_index)),
		.wr_addr (AW'(req_s1.set_index)),
		.wr_row  (wr_row),
		.rd_row  (rd_row)
	);

	dflru_victim_scan #(
		.NUM_WAYS (NUM_WAYS),
		.WW       (WW)
	) u_victim_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_start),
		.stamps (rd_stamps),
		.dirty  (rd_dirty),
		.sts    (scan_sts)
	);

	// Hold the result until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= set_ok_s1 ? scan_sts.res : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Memory read and write never share a cycle
	a_mem_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_cmd.rd && mem_cmd.wr))
		else $error("row memory read and write in the same cycle");

	// Access clock never moves backward
	a_clock_mono: assert property (@(posedge clk) disable iff (!arst_n)
		clock_q >= $past(clock_q))
		else $error("access clock decreased");

	// No beat is taken while the victim scan runs
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		scan_sts.busy |-> !accept)
		else $error("request accepted during victim scan");

	// Scan start, write-back and result load are exclusive
	a_ctl_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({scan_start, mem_cmd.wr, rsp_load}))
		else $error("overlapping sequencer actions");

endmodule
`default_nettype wire

@@ rtl/core/dflru_row_mem.sv @@
// Row memory: one row per set holding all way stamps and dirty bits.
// Uses dflru_pkg; per-row valid flops make unwritten rows read as zero.
`default_nettype none
module dflru_row_mem #(
	parameter int NUM_SETS = dflru_pkg::DEF_NUM_SETS,
	parameter int ROW_W    = 264,
	parameter int AW       = 6
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dflru_pkg::mem_cmd_t cmd,
	input  wire logic [AW-1:0]       rd_addr,
	input  wire logic [AW-1:0]       wr_addr,
	input  wire logic [ROW_W-1:0]    wr_row,
	output logic [ROW_W-1:0]         rd_row
);
	import dflru_pkg::*;

	logic [ROW_W-1:0] mem [NUM_SETS];
	logic [ROW_W-1:0] rd_q;
	logic             rd_vld_q;
	logic             row_vld_q [NUM_SETS];

	// Write and read the array, read data registered
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[wr_addr] <= wr_row;
		end
		if (cmd.rd) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Track which rows have ever been written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q <= 1'b0;
			for (int i = 0; i < NUM_SETS; i++) begin
				row_vld_q[i] <= 1'b0;
			end
		end else begin
			if (cmd.wr) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (cmd.rd) begin
				rd_vld_q <= row_vld_q[rd_addr];
			end
		end
	end

	// Unwritten rows read as the reset value
	assign rd_row = rd_vld_q ? rd_q : '0;

endmodule
`default_nettype wire

@@ rtl/core/dflru_victim_scan.sv @@
// Serial victim search: one way per cycle through a shared 33-bit compare.
// Uses dflru_pkg; key is {clean, stamp} so dirty ways rank first.
`default_nettype none
module dflru_victim_scan #(
	parameter int NUM_WAYS = dflru_pkg::DEF_NUM_WAYS,
	parameter int WW       = 3
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      start,
	input  wire logic [NUM_WAYS-1:0][dflru_pkg::STAMP_W-1:0] stamps,
	input  wire logic [NUM_WAYS-1:0]                       dirty,
	output dflru_pkg::scan_sts_t                           sts
);
	import dflru_pkg::*;

	logic [WW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             found_q;
	logic [KEY_W-1:0] best_key_q;
	logic [WW-1:0]    best_way_q;
	logic [KEY_W-1:0] key_cur;
	logic             take;
	logic             last;

	// Compare the current way against the best so far
	always_comb begin
		key_cur = {~dirty[cnt_q], stamps[cnt_q]};
		take    = !found_q || (key_cur < best_key_q);
		last    = (cnt_q == WW'(NUM_WAYS - 1));
	end

	// Advance the scan counter and control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			found_q <= 1'b0;
		end else if (start) begin
			cnt_q   <= '0;
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
			found_q <= 1'b0;
		end else if (busy_q) begin
			found_q <= 1'b1;
			if (last) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Hold the best candidate
	always_ff @(posedge clk) begin
		if (busy_q && !start && take) begin
			best_key_q <= key_cur;
			best_way_q <= cnt_q;
		end
	end

	always_comb begin
		sts.busy             = busy_q;
		sts.done             = done_q;
		sts.res.victim_way   = WAY_IDX_W'(best_way_q);
		sts.res.victim_dirty = ~best_key_q[KEY_W-1];
	end

endmodule
`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for dirty_first_lru_replacer: directed table, then random accesses.
// Depends on dflru_pkg and the replacer RTL; predicts victims from its own copy of the set state.
`timescale 1ns / 100ps
module tb;
	import dflru_pkg::*;

	localparam int NUM_SETS   = DEF_NUM_SETS;
	localparam int NUM_WAYS   = DEF_NUM_WAYS;
	localparam int ENTRIES    = NUM_SETS * NUM_WAYS;
	localparam int RAND_ITEMS = 550;
	// Worst case per beat: a query, a full output register, a long stall and a gap
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		req_t r;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Predicted replacement state
	logic [STAMP_W-1:0] way_stamp [ENTRIES];
	bit                 way_dirty [ENTRIES];
	logic [STAMP_W-1:0] tick_count;

	rsp_t               victim_q [$];
	dir_row_t           dir_tab [$];
	logic [SET_IDX_W-1:0] hot_set [4];
	int                 mismatch_cnt = 0;
	int                 items_sent = 0;
	int                 burst_left = 0;
	int                 cycle_cnt = 0;
	int                 stall_mode = 0;
	int                 stall_left = 0;

	dirty_first_lru_replacer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Advance the expected state by one accepted beat; return the victim for a query
	function automatic void predict_access(input req_t r, output bit has_rsp, output rsp_t pr);
		int e;
		bit have_d;
		bit have_c;
		logic [STAMP_W-1:0] sd;
		logic [STAMP_W-1:0] sc;
		int bd;
		int bc;
		has_rsp = 1'b0;
		pr = '0;
		have_d = 1'b0;
		have_c = 1'b0;
		sd = '0;
		sc = '0;
		bd = 0;
		bc = 0;
		if (r.action == ACT_VICTIM) begin
			has_rsp = 1'b1;
			if (int'(r.set_index) < NUM_SETS) begin
				for (int w = 0; w < NUM_WAYS; w++) begin
					e = int'(r.set_index) * NUM_WAYS + w;
					if (way_dirty[e]) begin
						if (!have_d || way_stamp[e] < sd) begin
							have_d = 1'b1;
							sd = way_stamp[e];
							bd = w;
						end
					end else begin
						if (!have_c || way_stamp[e] < sc) begin
							have_c = 1'b1;
							sc = way_stamp[e];
							bc = w;
						end
					end
				end
				if (have_d) begin
					pr.victim_way = bd[WAY_IDX_W-1:0];
					pr.victim_dirty = 1'b1;
				end else begin
					pr.victim_way = bc[WAY_IDX_W-1:0];
					pr.victim_dirty = 1'b0;
				end
			end
			return;
		end
		// Drop accesses outside the geometry; the clock does not move
		if (int'(r.set_index) >= NUM_SETS || int'(r.way) >= NUM_WAYS)
			return;
		e = int'(r.set_index) * NUM_WAYS + int'(r.way);
		if (r.action == ACT_INVAL) begin
			way_stamp[e] = '0;
			way_dirty[e] = 1'b0;
			return;
		end
		// Saturating access clock stamps touches and fills
		if (tick_count != STAMP_MAX)
			tick_count = tick_count + 1'b1;
		way_stamp[e] = tick_count;
		if (r.action == ACT_TOUCH) begin
			if (r.is_write)
				way_dirty[e] = 1'b1;
		end else begin
			way_dirty[e] = r.is_write;
		end
	endfunction

	function automatic dir_row_t mk_row(action_t a, int s, int w, bit wr, bit typed, int ew, bit ed);
		dir_row_t row;
		row.r.action = a;
		row.r.set_index = s[SET_IDX_W-1:0];
		row.r.way = w[WAY_IDX_W-1:0];
		row.r.is_write = wr;
		row.typed = typed;
		row.want.victim_way = ew[WAY_IDX_W-1:0];
		row.want.victim_dirty = ed;
		return row;
	endfunction

	function automatic req_t random_access();
		req_t r;
		int k;
		if ($urandom_range(0, 9) < 7)
			r.set_index = hot_set[$urandom_range(0, 3)];
		else
			r.set_index = SET_IDX_W'($urandom_range(0, NUM_SETS - 1));
		r.way = WAY_IDX_W'($urandom_range(0, NUM_WAYS - 1));
		r.is_write = 1'($urandom_range(0, 1));
		k = $urandom_range(0, 9);
		r.action = (k < 1) ? ACT_INVAL : (k < 4) ? ACT_TOUCH : (k < 7) ? ACT_FILL : ACT_VICTIM;
		return r;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("%0t mismatch: %s", $time, what);
		mismatch_cnt++;
	endtask

	// Insert an idle gap when the current burst is used up
	task automatic pace();
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
		end else begin
			burst_left--;
		end
	endtask

	// Offer one beat and hold it until accepted; queue the victim it should produce
	task automatic send_beat(input req_t r, input bit typed, input rsp_t want);
		bit got;
		rsp_t pr;
		pace();
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		predict_access(r, got, pr);
		if (got)
			victim_q.push_back(typed ? want : pr);
		items_sent++;
	endtask

	// Hold off the sender until every queued victim has come out
	task automatic drain_results();
		req_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (victim_q.size() != 0);
	endtask

	// Receiver stall pattern: switch to a random mode when the current run is used up
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 80);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= 1'($urandom_range(0, 1));
			2: rsp_stall <= (stall_left % 8) < 3;
			default: rsp_stall <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Compare each accepted result beat with the oldest expected victim
	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (victim_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected result way=%0d dirty=%0d",
					rsp.victim_way, rsp.victim_dirty));
			end else begin
				want = victim_q.pop_front();
				if (rsp.victim_way !== want.victim_way)
					flag_mismatch($sformatf("victim_way got %0d want %0d",
						rsp.victim_way, want.victim_way));
				if (rsp.victim_dirty !== want.victim_dirty)
					flag_mismatch($sformatf("victim_dirty got %0d want %0d",
						rsp.victim_dirty, want.victim_dirty));
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin : stimulus
		req_t r;
		bit wr;
		int s;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		tick_count = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			way_stamp[i] = '0;
			way_dirty[i] = 1'b0;
		end

		// Directed rows: queries right after reset, top set and way, dirty priority
		dir_tab.push_back(mk_row(ACT_VICTIM, 0, 7, 1, 1, 0, 0));
		dir_tab.push_back(mk_row(ACT_VICTIM, 63, 0, 0, 1, 0, 0));
		dir_tab.push_back(mk_row(ACT_FILL, 63, 7, 1, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_VICTIM, 63, 3, 0, 1, 7, 1));
		dir_tab.push_back(mk_row(ACT_TOUCH, 63, 0, 1, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_VICTIM, 63, 0, 1, 1, 7, 1));
		dir_tab.push_back(mk_row(ACT_INVAL, 63, 7, 1, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_VICTIM, 63, 7, 0, 1, 0, 1));
		// Touch without write keeps the dirty mark
		dir_tab.push_back(mk_row(ACT_TOUCH, 63, 0, 0, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_VICTIM, 63, 5, 1, 1, 0, 1));
		// Read fill clears it
		dir_tab.push_back(mk_row(ACT_FILL, 63, 0, 0, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_VICTIM, 63, 0, 0, 0, 0, 0));
		// Fill a whole set clean, then refresh way 0 and invalidate way 3
		for (int w = 0; w < NUM_WAYS; w++)
			dir_tab.push_back(mk_row(ACT_FILL, 0, w, 0, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_TOUCH, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_VICTIM, 0, 2, 1, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_INVAL, 0, 3, 0, 0, 0, 0));
		dir_tab.push_back(mk_row(ACT_VICTIM, 0, 0, 0, 1, 3, 0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_beat(dir_tab[i].r, dir_tab[i].typed, dir_tab[i].want);
		drain_results();

		// Random part: mostly accesses on a few hot sets, with whole-set sweeps
		hot_set[0] = '0;
		hot_set[1] = SET_IDX_W'(NUM_SETS - 1);
		hot_set[2] = SET_IDX_W'($urandom_range(0, NUM_SETS - 1));
		hot_set[3] = SET_IDX_W'($urandom_range(0, NUM_SETS - 1));
		items_sent = 0;
		while (items_sent < RAND_ITEMS) begin
			if ($urandom_range(0, 99) < 6) begin
				// Sweep: fill every way of one set, then query it
				s = hot_set[$urandom_range(0, 3)];
				wr = 1'($urandom_range(0, 1));
				for (int w = 0; w < NUM_WAYS; w++) begin
					r.action = ACT_FILL;
					r.set_index = s[SET_IDX_W-1:0];
					r.way = w[WAY_IDX_W-1:0];
					r.is_write = ($urandom_range(0, 3) == 0) ? ~wr : wr;
					send_beat(r, 1'b0, '0);
				end
				r.action = ACT_VICTIM;
				r.way = WAY_IDX_W'($urandom_range(0, NUM_WAYS - 1));
				r.is_write = 1'($urandom_range(0, 1));
				send_beat(r, 1'b0, '0);
			end else begin
				send_beat(random_access(), 1'b0, '0);
			end
			if (items_sent % 100 == 0)
				hot_set[$urandom_range(2, 3)] = SET_IDX_W'($urandom_range(0, NUM_SETS - 1));
			if (items_sent == RAND_ITEMS / 2)
				drain_results();
		end

		// Let the last results and any trailing write-back finish
		drain_results();
		repeat (NUM_WAYS + 8) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule
